FILE: rtl/sitd_pkg.sv
package sitd_pkg;

  // Default width of the incoming two's-complement value.
  localparam int VALUE_WIDTH_DEF = 32;

  // Shift-and-add-3 steps carried out in one conversion stage.
  localparam int BITS_PER_STAGE = 8;

  // One decimal digit in BCD.
  localparam int DIGIT_WIDTH = 4;

  // Width of an emitted character code.
  localparam int CHAR_WIDTH = 6;

  // Character codes, cut to the six bits that leave the block.
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

endpackage

FILE: rtl/sitd_magnitude.sv
// Entry stage: takes the request, registers its sign and forms the magnitude.
module sitd_magnitude #(
  parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [VALUE_WIDTH-1:0] up_value,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic                   dn_sign,
  output logic [VALUE_WIDTH-1:0] dn_mag
);

  logic                   valid_r;
  logic                   sign_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic [VALUE_WIDTH-1:0] mag_nxt;

  // The stage takes a new request when it is empty or its content moves on.
  assign up_ready = !valid_r || dn_ready;

  // Unsigned negation also gives the right magnitude for the most negative value.
  assign mag_nxt = up_value[VALUE_WIDTH-1] ? (~up_value + 1'b1) : up_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      sign_r <= up_value[VALUE_WIDTH-1];
      mag_r  <= mag_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_sign  = sign_r;
  assign dn_mag   = mag_r;

endmodule

FILE: rtl/sitd_dabble_stage.sv
// One conversion stage: a group of shift-and-add-3 steps moving magnitude bits
// into the BCD digits, most significant bit first.
module sitd_dabble_stage #(
  parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEF,
  parameter int NUM_DIGITS  = 10,
  parameter int STAGE       = 0
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       up_valid,
  output logic                                       up_ready,
  input  logic                                       up_sign,
  input  logic [NUM_DIGITS*sitd_pkg::DIGIT_WIDTH-1:0] up_bcd,
  input  logic [VALUE_WIDTH-1:0]                     up_mag,
  output logic                                       dn_valid,
  input  logic                                       dn_ready,
  output logic                                       dn_sign,
  output logic [NUM_DIGITS*sitd_pkg::DIGIT_WIDTH-1:0] dn_bcd,
  output logic [VALUE_WIDTH-1:0]                     dn_mag
);

  localparam int DW       = sitd_pkg::DIGIT_WIDTH;
  localparam int BCD_BITS = NUM_DIGITS * DW;
  localparam int STEPS    = sitd_pkg::BITS_PER_STAGE;

  logic                   valid_r;
  logic                   sign_r;
  logic [BCD_BITS-1:0]    bcd_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic [BCD_BITS-1:0]    bcd_nxt;
  logic [VALUE_WIDTH-1:0] mag_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Each step corrects every digit of five or more, then shifts one bit in.
  // Steps past the value width are left out in the final stage.
  always_comb begin
    bcd_nxt = up_bcd;
    mag_nxt = up_mag;
    for (int j = 0; j < STEPS; j++) begin
      if (STAGE * STEPS + j < VALUE_WIDTH) begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
          if (bcd_nxt[d*DW +: DW] > 4'd4) begin
            bcd_nxt[d*DW +: DW] = bcd_nxt[d*DW +: DW] + 4'd3;
          end
        end
        bcd_nxt = {bcd_nxt[BCD_BITS-2:0], mag_nxt[VALUE_WIDTH-1]};
        mag_nxt = {mag_nxt[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      sign_r <= up_sign;
      bcd_r  <= bcd_nxt;
      mag_r  <= mag_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_sign  = sign_r;
  assign dn_bcd   = bcd_r;
  assign dn_mag   = mag_r;

endmodule

FILE: rtl/sitd_emitter.sv
// Character emitter: holds one converted value and sends its text one character per
// cycle while out_ready is high: minus sign if negative, then digits from the top down.
module sitd_emitter #(
  parameter int NUM_DIGITS = 10
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       up_valid,
  output logic                                       up_ready,
  input  logic                                       up_sign,
  input  logic [NUM_DIGITS*sitd_pkg::DIGIT_WIDTH-1:0] up_bcd,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [sitd_pkg::CHAR_WIDTH-1:0]            out_char_code,
  output logic                                       out_last_char
);

  localparam int DW       = sitd_pkg::DIGIT_WIDTH;
  localparam int BCD_BITS = NUM_DIGITS * DW;
  localparam int IW       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic                busy_r;
  logic                sign_pend_r;
  logic [IW-1:0]       idx_r;
  logic [BCD_BITS-1:0] digits_r;
  logic [IW-1:0]       top_idx;
  logic [DW-1:0]       cur_digit;
  logic                is_last;
  logic                load;
  logic                take;

  // Position of the highest non-zero digit; a zero value points at digit 0.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (up_bcd[d*DW +: DW] != '0) begin
        top_idx = IW'(d);
      end
    end
  end

  assign is_last  = !sign_pend_r && (idx_r == '0);
  assign take     = busy_r && out_ready;
  assign up_ready = !busy_r || (out_ready && is_last);
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (take && is_last) begin
      busy_r <= 1'b0;
    end
  end

  // The sign goes out first; after it the digit pointer walks down to zero.
  always_ff @(posedge clk) begin
    if (load) begin
      sign_pend_r <= up_sign;
      idx_r       <= top_idx;
      digits_r    <= up_bcd;
    end else if (take) begin
      if (sign_pend_r) begin
        sign_pend_r <= 1'b0;
      end else if (!is_last) begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  assign cur_digit     = digits_r[{idx_r, 2'b00} +: DW];
  assign out_valid     = busy_r;
  assign out_last_char = is_last;
  assign out_char_code = sign_pend_r ? sitd_pkg::CHAR_MINUS
                                     : sitd_pkg::CHAR_ZERO + {2'b00, cur_digit};

endmodule

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// Channel  | Ports                                      | Direction
// ---------+--------------------------------------------+----------
// input    | in_valid, in_ready, in_value               | in
// result   | out_valid, out_ready, out_char_code,       | out
//          | out_last_char                              |
//
// A value passes an entry stage and ceil(VALUE_WIDTH/8) conversion stages (four
// at 32 bits), each of them registered, on its way to the emitter.
// The emitter sends one character per cycle while out_ready is high, a rate set
// by the single output port; a value's text has 1 to 11 characters at 32 bits.
// Reset clears the valid bit of every stage and the emitter's busy flag.
// A stall at the output holds every stage that is full; nothing is dropped.
module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [VALUE_WIDTH-1:0]          in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sitd_pkg::CHAR_WIDTH-1:0] out_char_code,
  output logic                            out_last_char
);

  // Enough digits for 2^(VALUE_WIDTH-1), using log10(2) ~ 0.30103.
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_BITS   = NUM_DIGITS * sitd_pkg::DIGIT_WIDTH;
  localparam int NUM_STAGES =
    (VALUE_WIDTH + sitd_pkg::BITS_PER_STAGE - 1) / sitd_pkg::BITS_PER_STAGE;

  logic                   valid_w [NUM_STAGES+1];
  logic                   ready_w [NUM_STAGES+1];
  logic                   sign_w  [NUM_STAGES+1];
  logic [BCD_BITS-1:0]    bcd_w   [NUM_STAGES+1];
  logic [VALUE_WIDTH-1:0] mag_w   [NUM_STAGES+1];

  // Entry stage.
  sitd_magnitude #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_magnitude (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_value (in_value),
    .dn_valid (valid_w[0]),
    .dn_ready (ready_w[0]),
    .dn_sign  (sign_w[0]),
    .dn_mag   (mag_w[0])
  );

  assign bcd_w[0] = '0;

  // Conversion stages.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    sitd_dabble_stage #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS),
      .STAGE       (s)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_w[s]),
      .up_ready (ready_w[s]),
      .up_sign  (sign_w[s]),
      .up_bcd   (bcd_w[s]),
      .up_mag   (mag_w[s]),
      .dn_valid (valid_w[s+1]),
      .dn_ready (ready_w[s+1]),
      .dn_sign  (sign_w[s+1]),
      .dn_bcd   (bcd_w[s+1]),
      .dn_mag   (mag_w[s+1])
    );
  end

  // Character emitter.
  sitd_emitter #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emitter (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (valid_w[NUM_STAGES]),
    .up_ready      (ready_w[NUM_STAGES]),
    .up_sign       (sign_w[NUM_STAGES]),
    .up_bcd        (bcd_w[NUM_STAGES]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // Every magnitude bit has been shifted into the digits by the last stage.
  a_mag_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    valid_w[NUM_STAGES] |-> (mag_w[NUM_STAGES] == '0))
    else $error("magnitude bits left over after the last conversion stage");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_code == sitd_pkg::CHAR_MINUS)) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  // Only a minus sign or a decimal digit leaves the block.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code == sitd_pkg::CHAR_MINUS) ||
                   ((out_char_code >= sitd_pkg::CHAR_ZERO) &&
                    (out_char_code <= sitd_pkg::CHAR_ZERO + 6'd9))))
    else $error("character code outside minus and digits");

  // Reset empties the emitter.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

FILE: dv/tb_signed_int_to_decimal_ascii_top.sv
module tb_signed_int_to_decimal_ascii_top;

  localparam int W            = sitd_pkg::VALUE_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 108;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 6;
  // Window of cycles in which neither side idles.
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 1100;

  typedef struct packed {
    logic [sitd_pkg::CHAR_WIDTH-1:0] code;
    logic                            is_last;
  } text_char_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [W-1:0]                    in_value = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [sitd_pkg::CHAR_WIDTH-1:0] out_char_code;
  logic                            out_last_char;

  logic [W-1:0] pending_values[$];
  text_char_t   expected_text[$];
  int           total_requests = 0;
  int           sent_requests = 0;
  int           err_count = 0;
  int           cycle_count = 0;

  signed_int_to_decimal_ascii_top #(
    .VALUE_WIDTH(W)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  always #1 clk = ~clk;

  // Renders one value as decimal text and queues the characters it should produce.
  function automatic void queue_decimal_text(logic [W-1:0] v);
    logic [W-1:0] mag;
    logic [3:0]   digits[0:19];
    int           nd;
    text_char_t   c;
    nd = 0;
    if (v == '0) begin
      c.code    = sitd_pkg::CHAR_ZERO;
      c.is_last = 1'b1;
      expected_text.push_back(c);
      return;
    end
    // Unsigned negation gives the exact magnitude of the most negative value too.
    mag = v[W-1] ? (~v + 1'b1) : v;
    while (mag != '0) begin
      digits[nd] = 4'(mag % 10);
      mag        = mag / 10;
      nd++;
    end
    if (v[W-1]) begin
      c.code    = sitd_pkg::CHAR_MINUS;
      c.is_last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code    = sitd_pkg::CHAR_ZERO + sitd_pkg::CHAR_WIDTH'(digits[i]);
      c.is_last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // Picks a random value, mostly with a random number of digits and a random sign.
  function automatic logic [W-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     nd;
    if ($urandom_range(3) == 0) begin
      return W'($urandom);
    end
    nd = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < nd; i++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (hi > 64'sd2147483647) begin
      hi = 64'sd2147483647;
    end
    if (nd == 1) begin
      lo = 0;
    end
    mag = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
    if ($urandom_range(1) == 1) begin
      // One past the top of the range reaches the most negative value.
      if (mag == 64'sd2147483647 && $urandom_range(1) == 1) begin
        mag = 64'sd2147483648;
      end
      mag = -mag;
    end
    return W'(mag);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  function automatic bit quiet_window();
    return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Request driver: predicts on acceptance, then offers the next pending value.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        queue_decimal_text(in_value);
        sent_requests <= sent_requests + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_values.size() != 0
            && (quiet_window() || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and comparison with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window() || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected character", out_char_code, -1);
        end else begin
          text_char_t want;
          want = expected_text.pop_front();
          if (out_char_code !== want.code) begin
            report_mismatch("char_code", out_char_code, want.code);
          end
          if (out_last_char !== want.is_last) begin
            report_mismatch("last_char", out_last_char, want.is_last);
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [W-1:0] directed[$];
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10,
                 32'd99, 32'd100, -32'sd100, 32'd999999999, 32'd1000000000,
                 -32'sd1000000000, 32'h7fffffff, 32'h80000000, 32'h80000001,
                 32'h55555555, 32'haaaaaaaa, 32'd123456789, -32'sd987654321,
                 32'd2147483640, 32'd5};
    foreach (directed[i]) begin
      pending_values.push_back(directed[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_values.push_back(random_value());
    end
    total_requests = pending_values.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (sent_requests == total_requests && expected_text.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sitd_pkg.sv
rtl/sitd_magnitude.sv
rtl/sitd_dabble_stage.sv
rtl/sitd_emitter.sv
rtl/signed_int_to_decimal_ascii_top.sv
dv/tb_signed_int_to_decimal_ascii_top.sv
